FILE: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BF3_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define BF3_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define BF3_ASSERT(lbl, clk, rstn, prop)

`define BF3_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/bf3_pkg.sv
package bf3_pkg;

    localparam int PIX_W  = 8;
    localparam int SUM_W  = 12;
    localparam int CNT_W  = 4;
    localparam int ROWS_W = 2 * PIX_W;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int RECIP3 = 2731;
    localparam int SHIFT3 = 13;
    localparam int RECIP9 = 1821;
    localparam int SHIFT9 = 14;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [8:0] t_cells;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_SUM,
        S_DIV
    } t_state;

    typedef struct packed {
        logic       col_zero;
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } t_win_ctl;

    function automatic t_pix bf3_div(input logic [SUM_W-1:0] sum,
                                     input logic [CNT_W-1:0] cnt);
        logic [2*SUM_W-1:0]        p3;
        logic [2*SUM_W-1:0]        p9;
        logic [2*SUM_W-SHIFT3-1:0] q3;
        logic [2*SUM_W-SHIFT9-1:0] q9;
        t_pix                      q;
        p3 = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP3);
        p9 = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP9);
        q3 = p3[2*SUM_W-1:SHIFT3];
        q9 = p9[2*SUM_W-1:SHIFT9];
        unique case (cnt)
            4'd1:    q = sum[PIX_W-1:0];
            4'd2:    q = sum[PIX_W:1];
            4'd3:    q = q3[PIX_W-1:0];
            4'd4:    q = sum[PIX_W+1:2];
            4'd6:    q = q3[PIX_W:1];
            4'd9:    q = q9[PIX_W-1:0];
            default: q = '0;
        endcase
        return q;
    endfunction

endpackage

FILE: rtl/bf3_ram.sv
module bf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bf3_win.sv
module bf3_win import bf3_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_win_ctl          i_ctl,
    input  t_pix              i_pixel,
    input  logic [ROWS_W-1:0] i_rows,
    output logic [ROWS_W-1:0] o_rows_wr,
    output t_cells            o_cells,
    output logic [CNT_W-1:0]  o_cnt
);

    t_cells           r_cell;
    t_cells           n_cell;
    t_cells           src;
    t_cells           r_msk;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       row_n;
    logic [1:0]       col_n;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_cell[r*3]     = r_cell[r*3 + 1];
            n_cell[r*3 + 1] = r_cell[r*3 + 2];
        end
        n_cell[2] = i_rows[ROWS_W-1:PIX_W];
        n_cell[5] = i_rows[PIX_W-1:0];
        n_cell[8] = i_pixel;
    end

    // centered on the previous row end before the shift, on the middle column after
    assign src = i_ctl.col_zero ? r_cell : n_cell;

    assign row_n = 2'(i_ctl.row_ok[0]) + 2'(i_ctl.row_ok[1]) + 2'(i_ctl.row_ok[2]);
    assign col_n = 2'(i_ctl.col_ok[0]) + 2'(i_ctl.col_ok[1]) + 2'(i_ctl.col_ok[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else if (i_step) begin
            r_cell <= n_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_msk[r*3 + k] <= (i_ctl.row_ok[r] && i_ctl.col_ok[k]) ?
                                      src[r*3 + k] : '0;
                end
            end
            r_cnt <= CNT_W'(row_n) * CNT_W'(col_n);
        end
    end

    assign o_rows_wr = {i_rows[PIX_W-1:0], i_pixel};
    assign o_cells   = r_msk;
    assign o_cnt     = r_cnt;

endmodule

FILE: rtl/bf3_mean.sv
module bf3_mean import bf3_pkg::*; (
    input  logic             i_clk,
    input  logic             i_load,
    input  t_cells           i_cells,
    input  logic [CNT_W-1:0] i_cnt,
    output t_pix             o_mean
);

    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] n_sum;

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < 9; i++) begin
            n_sum = n_sum + SUM_W'(i_cells[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= n_sum;
            r_cnt <= i_cnt;
        end
    end

    assign o_mean = bf3_div(r_sum, r_cnt);

endmodule

FILE: rtl/box_filter_3x3_edge_aware.sv
// 3x3 box filter: floor of the mean of each pixel and its in-frame neighbors,
// dividing by 1, 2, 3, 4, 6 or 9 cells. Pixels enter in raster order
// (tuser = 0); after the last pixel, send frame_width + 1 drain ticks
// (tuser = 1) to flush the pending results. Results leave in raster order,
// each one frame_width + 1 requests behind its pixel, and the last result of
// a frame carries tlast and restarts the frame counters. A pixel or drain
// request taken out of turn is consumed without a result. A request taken into
// the window goes through accept, read-modify-write of the row-store RAM (one
// 16-bit word per column, registered read), sum of the window and divide by
// reciprocal table, then waits while its result meets a full output register;
// no new request is taken before it is done. A consumed request leaves it idle.
// The row-store RAM needs no clearing after reset. Register 0 (address 0)
// is the frame width, register 1 (address 4) the frame height, both 1 after
// reset, 0 acting as 1 and values above the maximum as the maximum; writing
// either restarts the frame and must happen only while the filter is idle.
`include "assert_macros.svh"

module box_filter_3x3_edge_aware import bf3_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]  s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] smoothed
    output logic        m_axis_tlast
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    t_state            r_state;
    t_state            n_state;
    logic [8:0]        r_cfg_w;
    logic [8:0]        r_cfg_h;
    logic [CW-1:0]     r_ci;
    logic [CW-1:0]     n_ci;
    logic [RW-1:0]     r_ri;
    logic [RW-1:0]     n_ri;
    t_pix              r_px;
    t_win_ctl          r_ctl;
    t_win_ctl          n_ctl;
    logic              r_emit;
    logic              r_last;
    logic [AW-1:0]     r_addr;
    t_pix              r_out_data;
    logic              r_out_last;
    logic              r_out_valid;

    logic [CW-1:0]     eff_w;
    logic [RW-1:0]     eff_h;
    logic [RW-1:0]     eff_h_inc;
    logic [CW-1:0]     ci_inc;
    logic              cfg_wr;
    logic              s_acc;
    logic              drop;
    logic              n_emit;
    logic              n_last;
    logic              ram_re;
    logic              ram_we;
    logic              win_step;
    logic              mean_load;
    logic              out_load;
    logic [ROWS_W-1:0] rows_rd;
    logic [ROWS_W-1:0] rows_wr;
    t_cells            cells;
    logic [CNT_W-1:0]  cnt;
    t_pix              mean;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 9'd1;
            r_cfg_h <= 9'd1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_cfg_w <= pwdata[8:0];
                REG_HEIGHT: r_cfg_h <= pwdata[8:0];
                default:    r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = 32'(r_cfg_w);
            REG_HEIGHT: prdata = 32'(r_cfg_h);
            default:    prdata = '0;
        endcase
    end

    // clamp sizes
    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = CW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            eff_h = RW'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            eff_h = RW'(MAX_HEIGHT);
        end else begin
            eff_h = RW'(r_cfg_h);
        end
    end

    assign eff_h_inc = eff_h + RW'(1);
    assign ci_inc    = r_ci + CW'(1);

    // request decode
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign drop  = (s_axis_tuser[0] == OP_PIXEL) ? (r_ri >= eff_h) : (r_ri < eff_h);

    always_comb begin
        if (r_ci == '0) begin
            n_ctl.col_zero = 1'b1;
            n_ctl.row_ok   = {r_ri <= eff_h, 1'b1, r_ri > RW'(2)};
            n_ctl.col_ok   = {1'b1, eff_w > CW'(1), 1'b0};
            n_emit         = r_ri > RW'(1);
        end else begin
            n_ctl.col_zero = 1'b0;
            n_ctl.row_ok   = {r_ri < eff_h, 1'b1, r_ri > RW'(1)};
            n_ctl.col_ok   = {1'b1, 1'b1, r_ci > CW'(1)};
            n_emit         = r_ri != '0;
        end
        n_last = (r_ci == '0) && (r_ri == eff_h_inc);
        if (n_last) begin
            n_ci = '0;
            n_ri = '0;
        end else if (ci_inc >= eff_w) begin
            n_ci = '0;
            n_ri = r_ri + RW'(1);
        end else begin
            n_ci = ci_inc;
            n_ri = r_ri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci   <= '0;
            r_ri   <= '0;
            r_emit <= 1'b0;
            r_last <= 1'b0;
        end else if (cfg_wr) begin
            r_ci <= '0;
            r_ri <= '0;
        end else if (s_acc && !drop) begin
            r_ci   <= n_ci;
            r_ri   <= n_ri;
            r_emit <= n_emit;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && !drop) begin
            r_px   <= (s_axis_tuser[0] == OP_DRAIN) ? '0 : s_axis_tdata;
            r_ctl  <= n_ctl;
            r_addr <= r_ci[AW-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && !drop) begin
                    n_state = S_RMW;
                end
            end
            S_RMW:  n_state = S_SUM;
            S_SUM:  n_state = S_DIV;
            S_DIV: begin
                if (!r_emit || !r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        win_step      = 1'b0;
        ram_we        = 1'b0;
        mean_load     = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_RMW: begin
                win_step = 1'b1;
                ram_we   = 1'b1;
            end
            S_SUM:  mean_load = 1'b1;
            S_DIV:  out_load  = r_emit && (!r_out_valid || m_axis_tready);
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign ram_re = s_acc && !drop;

    bf3_ram #(
        .WIDTH (ROWS_W),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (rows_wr),
        .i_re    (ram_re),
        .i_raddr (r_ci[AW-1:0]),
        .o_rdata (rows_rd)
    );

    bf3_win u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (win_step),
        .i_ctl     (r_ctl),
        .i_pixel   (r_px),
        .i_rows    (rows_rd),
        .o_rows_wr (rows_wr),
        .o_cells   (cells),
        .o_cnt     (cnt)
    );

    bf3_mean u_mean (
        .i_clk   (i_clk),
        .i_load  (mean_load),
        .i_cells (cells),
        .i_cnt   (cnt),
        .o_mean  (mean)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= mean;
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    `BF3_ASSERT(a_col_in_range, i_clk, i_rst_n, r_ci < eff_w)
    `BF3_ASSERT(a_row_in_range, i_clk, i_rst_n, r_ri <= eff_h_inc)
    `BF3_ASSERT_IMPL(a_load_from_div, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_DIV))
    `BF3_ASSERT_IMPL(a_last_restarts, i_clk, i_rst_n, out_load && r_last, r_ci == '0 && r_ri == '0)

endmodule

FILE: bench/box_filter_3x3_edge_aware_tb.sv
`timescale 1ns / 100ps

module box_filter_3x3_edge_aware_tb import bf3_pkg::*;;

    localparam int LINE_MAX   = 256;
    localparam int ITEM_GOAL  = 1100;
    localparam int IDLE_WAIT  = 16;

    typedef struct {
        bit [7:0] smoothed;
        bit       last;
    } t_mean_due;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;
    typedef enum {PX_ANY, PX_RAIL, PX_HIGH, PX_LOW} t_pix_flavor;

    class neighborhood_mean_board;
        bit [8:0]  width_reg;
        bit [8:0]  height_reg;
        bit [7:0]  upper_line [LINE_MAX];
        bit [7:0]  lower_line [LINE_MAX];
        bit [7:0]  win [9];
        int        col_in;
        int        row_in;
        int        col_out;
        int        row_out;
        t_mean_due means_due [$];
        int        failures;

        function new();
            width_reg  = 1;
            height_reg = 1;
            foreach (upper_line[i]) begin
                upper_line[i] = 0;
                lower_line[i] = 0;
            end
            foreach (win[i]) win[i] = 0;
            failures = 0;
            restart();
        endfunction

        static function int size_in_use(int v);
            if (v < 1) return 1;
            if (v > LINE_MAX) return LINE_MAX;
            return v;
        endfunction

        function void restart();
            col_in  = 0;
            row_in  = 0;
            col_out = 0;
            row_out = 0;
        endfunction

        function void set_register(logic idx, bit [8:0] v);
            if (idx == REG_WIDTH) width_reg = v;
            else height_reg = v;
            restart();
        endfunction

        function bit [7:0] mean_at(int wc0, int ro, int co, int w, int h);
            int sum;
            int cnt;
            int r;
            int c;
            int wc;
            sum = 0;
            cnt = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    r  = ro + dr;
                    c  = co + dc;
                    wc = wc0 + dc;
                    if (r < 0 || r >= h || c < 0 || c >= w || wc < 0 || wc > 2) continue;
                    sum += win[(dr + 1) * 3 + wc];
                    cnt++;
                end
            end
            return (cnt != 0) ? 8'(sum / cnt) : 8'd0;
        endfunction

        function void slide(int col, bit [7:0] px);
            bit [7:0] top;
            bit [7:0] mid;
            top = upper_line[col];
            mid = lower_line[col];
            for (int r = 0; r < 3; r++) begin
                win[r * 3]     = win[r * 3 + 1];
                win[r * 3 + 1] = win[r * 3 + 2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = px;
            upper_line[col] = mid;
            lower_line[col] = px;
        endfunction

        function void take_request(logic op, bit [7:0] px);
            int        w;
            int        h;
            int        ci;
            int        ri;
            bit        fire;
            bit [7:0]  mean;
            t_mean_due due;
            w    = size_in_use(width_reg);
            h    = size_in_use(height_reg);
            ci   = col_in;
            ri   = row_in;
            fire = 0;
            mean = 0;
            if (ci >= w) ci = 0;
            if (op == OP_PIXEL && ri >= h) return;
            if (op == OP_DRAIN && ri < h) return;
            if (op == OP_DRAIN) px = 0;
            if (ci == 0) begin
                if (ri >= 2) begin
                    row_out = ri - 2;
                    col_out = w - 1;
                    mean = mean_at(2, row_out, col_out, w, h);
                    fire = 1;
                end
                slide(ci, px);
            end else begin
                slide(ci, px);
                if (ri >= 1) begin
                    row_out = ri - 1;
                    col_out = ci - 1;
                    mean = mean_at(1, row_out, col_out, w, h);
                    fire = 1;
                end
            end
            ci++;
            if (ci >= w) begin
                ci = 0;
                ri++;
            end
            col_in = ci;
            row_in = ri;
            if (!fire) return;
            due.smoothed = mean;
            due.last     = (row_out == h - 1 && col_out == w - 1);
            if (due.last) restart();
            means_due.push_back(due);
        endfunction

        function void match_result(logic [7:0] got, logic got_last);
            t_mean_due want;
            if (means_due.size() == 0) begin
                $error("result with nothing due: smoothed %0d, frame_last %0b", got, got_last);
                failures++;
                return;
            end
            want = means_due.pop_front();
            if (got !== want.smoothed) begin
                $error("smoothed: expected %0d, actual %0d", want.smoothed, got);
                failures++;
            end
            if (got_last !== want.last) begin
                $error("frame_last: expected %0b, actual %0b", want.last, got_last);
                failures++;
            end
        endfunction

        function int pending();
            return means_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] pixel
    logic [0:0]  s_axis_tuser;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] smoothed
    logic        m_axis_tlast;

    neighborhood_mean_board board;
    int       items_sent;
    int       burst_left;
    bit       steady;
    int       rx_tick;
    t_rx_mode rx_mode;

    box_filter_3x3_edge_aware i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("box_filter_3x3_edge_aware_tb failed");
        $finish;
    end

    always @(posedge i_clk) begin
        rx_tick++;
        if (rx_tick % 97 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= (rx_tick % 4 == 0);
            default:   m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.match_result(m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic push_request(logic op, bit [7:0] px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (steady || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_request(op, px);
    endtask

    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write(logic idx, int value);
        logic [31:0] word;
        word = ($urandom & ~32'h1FF) | (value & 32'h1FF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_register(idx, word[8:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // cut < 0 runs the whole frame; otherwise drop the frame at that position
    task automatic stream_frame(int w, int h, int noise_pct, t_pix_flavor flavor, int cut);
        int       total;
        bit [7:0] px;
        total = w * h + w + 1;
        for (int k = 0; k < total; k++) begin
            if (k == cut) return;
            if ($urandom_range(0, 99) < noise_pct) begin
                push_request((k < w * h) ? OP_DRAIN : OP_PIXEL, 8'($urandom));
            end
            case (flavor)
                PX_ANY:  px = 8'($urandom);
                PX_RAIL: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                PX_HIGH: px = 8'($urandom_range(224, 255));
                default: px = 8'($urandom_range(0, 31));
            endcase
            push_request((k < w * h) ? OP_PIXEL : OP_DRAIN, px);
            items_sent++;
        end
    endtask

    initial begin
        int          w_val;
        int          h_val;
        int          new_w;
        int          new_h;
        int          phase;
        int          cut;
        int          w_eff;
        int          h_eff;
        bit          must_write;
        t_pix_flavor flavor;

        board      = new();
        items_sent = 0;
        burst_left = 0;
        steady     = 0;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero sizes act as a single-pixel frame
        apb_write(REG_WIDTH, 0);
        apb_write(REG_HEIGHT, 0);
        push_request(OP_PIXEL, 8'hFF);
        push_request(OP_DRAIN, 8'h00);
        push_request(OP_DRAIN, 8'h3C);
        items_sent += 3;

        // 3x3 frame with an early drain and a late pixel, both dropped
        settle_idle();
        apb_write(REG_WIDTH, 3);
        apb_write(REG_HEIGHT, 3);
        for (int k = 0; k < 13; k++) begin
            if (k == 4) push_request(OP_DRAIN, 8'hA5);
            if (k == 9) push_request(OP_PIXEL, 8'h5A);
            push_request((k < 9) ? OP_PIXEL : OP_DRAIN, (k % 3 == 1) ? 8'h00 : 8'hFF);
            items_sent++;
        end
        w_val = 3;
        h_val = 3;

        phase      = 0;
        must_write = 0;
        while (items_sent < ITEM_GOAL) begin
            new_w = w_val;
            new_h = h_val;
            if (phase == 2) begin
                new_w = 511;
                new_h = 1;
            end else if (phase == 5) begin
                new_w = 1;
                new_h = 256;
            end else if (must_write || $urandom_range(0, 9) < 7) begin
                new_w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
                new_h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                if ($urandom_range(0, 9) == 0) begin
                    new_w = $urandom_range(9, 40);
                    new_h = $urandom_range(1, 2);
                end
            end
            if (must_write || new_w != w_val || new_h != h_val) begin
                settle_idle();
                if (must_write || new_w != w_val) apb_write(REG_WIDTH, new_w);
                if (new_h != h_val) apb_write(REG_HEIGHT, new_h);
            end
            w_val = new_w;
            h_val = new_h;
            w_eff = neighborhood_mean_board::size_in_use(w_val);
            h_eff = neighborhood_mean_board::size_in_use(h_val);
            steady = ($urandom_range(0, 3) == 0);
            flavor = t_pix_flavor'($urandom_range(0, 3));
            cut = -1;
            if (phase != 2 && phase != 5 && $urandom_range(0, 15) == 0) begin
                cut = $urandom_range(0, w_eff * h_eff + w_eff);
            end
            stream_frame(w_eff, h_eff, $urandom_range(0, 1) ? 0 : $urandom_range(3, 15),
                         flavor, cut);
            must_write = (cut >= 0);
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("box_filter_3x3_edge_aware_tb passed");
        end else begin
            $display("box_filter_3x3_edge_aware_tb failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bf3_pkg.sv
rtl/bf3_ram.sv
rtl/bf3_win.sv
rtl/bf3_mean.sv
rtl/box_filter_3x3_edge_aware.sv
bench/box_filter_3x3_edge_aware_tb.sv
